[rtl/jsc_pkg.sv]
`timescale 1ns / 1ps

package jsc_pkg;

    // Host command opcodes
    localparam logic [7:0] OP_SET_LOW      = 8'h80;
    localparam logic [7:0] OP_READ_LOW     = 8'h81;
    localparam logic [7:0] OP_SET_HIGH     = 8'h82;
    localparam logic [7:0] OP_READ_HIGH    = 8'h83;
    localparam logic [7:0] OP_LOOP_ON      = 8'h84;
    localparam logic [7:0] OP_LOOP_OFF     = 8'h85;
    localparam logic [7:0] OP_SET_DIVISOR  = 8'h86;
    localparam logic [7:0] OP_FLUSH        = 8'h87;
    localparam logic [7:0] OP_IGNORE_88    = 8'h88;
    localparam logic [7:0] OP_IGNORE_89    = 8'h89;
    localparam logic [7:0] OP_DIV5_OFF     = 8'h8A;
    localparam logic [7:0] OP_DIV5_ON      = 8'h8B;
    localparam logic [7:0] OP_IGNORE_8C    = 8'h8C;
    localparam logic [7:0] OP_IGNORE_8D    = 8'h8D;
    localparam logic [7:0] OP_CLK_BYTES    = 8'h8E;
    localparam logic [7:0] OP_CLK_BYTES8   = 8'h8F;
    localparam logic [7:0] OP_IGNORE_96    = 8'h96;
    localparam logic [7:0] OP_IGNORE_97    = 8'h97;

    localparam logic [7:0] BAD_CMD_BYTE    = 8'hFA;
    localparam logic [7:0] ALL_ONES_BYTE   = 8'hFF;

    // Bit positions inside a shift opcode
    localparam int CMD_SPECIAL_BIT = 7;
    localparam int CMD_TMS_BIT     = 6;
    localparam int CMD_CAPTURE_BIT = 5;
    localparam int CMD_WTDI_BIT    = 4;
    localparam int CMD_LSB_BIT     = 3;
    localparam int CMD_BITMODE_BIT = 1;
    localparam int CMD_EDGE_BIT    = 0;

    // Shift modes
    localparam logic [2:0] MODE_MSB_E1 = 3'd0;
    localparam logic [2:0] MODE_MSB_E0 = 3'd1;
    localparam logic [2:0] MODE_LSB_E1 = 3'd2;
    localparam logic [2:0] MODE_LSB_E0 = 3'd3;
    localparam logic [2:0] MODE_TMS_E1 = 3'd4;
    localparam logic [2:0] MODE_TMS_E0 = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_REPLY = 3'd0;
    localparam logic [2:0] KIND_SHIFT = 3'd1;
    localparam logic [2:0] KIND_PINS  = 3'd2;
    localparam logic [2:0] KIND_CLOCK = 3'd3;
    localparam logic [2:0] KIND_FLUSH = 3'd4;

    // TDI hold codes for TMS shifts
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_LOW  = 2'd1;
    localparam logic [1:0] HOLD_HIGH = 2'd2;

    // Result queue geometry (depth must be a power of two)
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // Reciprocal of 129 scaled by 2^36, rounded up; exact for numerators below 2^25
    localparam int           RECIP_SHIFT = 36;
    localparam logic [28:0]  RECIP_129   = 29'd532709122;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [3:0] pin_levels;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [3:0]  pin_dir;
        logic [2:0]  shift_mode;
        logic [3:0]  bit_count;
        logic [16:0] repeat_count;
        logic        capture_tdo;
        logic [1:0]  tdi_hold;
        logic [19:0] clock_count;
        logic [17:0] half_period_delay;
        logic        loopback;
        logic        last;
    } out_word_t;

    // Results produced by one parsed byte
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } emit_t;

    typedef struct packed {
        logic        start;
        logic [15:0] divider;
        logic        div5;
    } delay_req_t;

    typedef struct packed {
        logic [RQ_CW-1:0] count;
        logic [RQ_CW-1:0] free;
    } rq_status_t;

    function automatic logic [4:0] fast_delay(input logic [2:0] idx);
        logic [4:0] v;
        case (idx)
            3'd0:    v = 5'd1;
            3'd1:    v = 5'd5;
            3'd2:    v = 5'd8;
            3'd3:    v = 5'd12;
            3'd4:    v = 5'd16;
            3'd5:    v = 5'd20;
            default: v = 5'd1;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] slow_delay(input logic [3:0] idx);
        logic [4:0] v;
        case (idx)
            4'd5:    v = 5'd2;
            4'd6:    v = 5'd3;
            4'd7:    v = 5'd4;
            4'd8:    v = 5'd4;
            4'd9:    v = 5'd5;
            4'd10:   v = 5'd6;
            4'd11:   v = 5'd7;
            4'd12:   v = 5'd8;
            4'd13:   v = 5'd8;
            4'd14:   v = 5'd8;
            4'd15:   v = 5'd9;
            default: v = 5'd1;
        endcase
        return v;
    endfunction

endpackage

[rtl/jsc_delay.sv]
`timescale 1ns / 1ps

module jsc_delay (
    input  logic                clk,
    input  logic                rst_n,
    input  jsc_pkg::delay_req_t dreq,
    output logic [17:0]         delay_value,
    output logic                busy
);

    logic        pend_reg;
    logic        small_reg, small_next;
    logic [4:0]  tab_reg, tab_next;
    logic [24:0] num_reg, num_next;
    logic [25:0] fast_num;
    logic [22:0] slow_num;
    logic [53:0] prod;
    logic [17:0] delay_reg, delay_next;

    // First step: table lookup or scaled numerator
    always_comb
    begin
        fast_num = 26'(dreq.divider) * 26'd1000 + 26'd290;
        slow_num = 23'(dreq.divider) * 23'd100 - 23'd255;
        if (dreq.div5)
        begin
            small_next = (dreq.divider < 16'd6);
            tab_next   = jsc_pkg::fast_delay(dreq.divider[2:0]);
            num_next   = fast_num[25:1];
        end
        else
        begin
            small_next = (dreq.divider < 16'd16);
            tab_next   = jsc_pkg::slow_delay(dreq.divider[3:0]);
            num_next   = 25'(slow_num);
        end
    end

    // Second step: divide by 129 through the reciprocal
    always_comb
    begin
        prod = 54'(num_reg) * 54'(jsc_pkg::RECIP_129);
        if (small_reg)
            delay_next = 18'(tab_reg);
        else
            delay_next = prod[jsc_pkg::RECIP_SHIFT +: 18];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            delay_reg <= 18'd1;
        end
        else
        begin
            pend_reg <= dreq.start;
            if (pend_reg)
                delay_reg <= delay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dreq.start)
        begin
            small_reg <= small_next;
            tab_reg   <= tab_next;
            num_reg   <= num_next;
        end
    end

    assign delay_value = delay_reg;
    assign busy        = pend_reg;

endmodule

[rtl/jsc_parser.sv]
`timescale 1ns / 1ps

module jsc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  jsc_pkg::in_word_t   item,
    input  logic [17:0]         delay_value,
    output jsc_pkg::emit_t      emit,
    output jsc_pkg::delay_req_t dreq
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_TMS,
        PH_PARAM0,
        PH_PARAM1
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  p0_reg, p0_next;
    logic        loop_reg, loop_next;
    logic        div5_reg, div5_next;
    logic [2:0]  mode_reg, mode_next;

    logic [7:0]  b;
    logic        bitmode;
    logic        tms;
    logic        wtdi;
    logic        cap;
    logic [15:0] param;
    logic [1:0]  n;
    logic        set_div;
    jsc_pkg::out_word_t r0, r1;

    function automatic jsc_pkg::out_word_t reply_word(input logic [7:0] data);
        jsc_pkg::out_word_t w;
        w           = '0;
        w.kind      = jsc_pkg::KIND_REPLY;
        w.data_byte = data;
        return w;
    endfunction

    function automatic jsc_pkg::out_word_t shift_word(
        input logic [7:0]  data,
        input logic [3:0]  bits,
        input logic [16:0] rep,
        input logic [1:0]  hold,
        input logic [2:0]  mode,
        input logic        capture
    );
        jsc_pkg::out_word_t w;
        w              = '0;
        w.kind         = jsc_pkg::KIND_SHIFT;
        w.data_byte    = data;
        w.shift_mode   = mode;
        w.bit_count    = bits;
        w.repeat_count = rep;
        w.capture_tdo  = capture;
        w.tdi_hold     = hold;
        return w;
    endfunction

    always_comb
    begin
        b       = item.rx_byte;
        bitmode = cmd_reg[jsc_pkg::CMD_BITMODE_BIT];
        tms     = cmd_reg[jsc_pkg::CMD_TMS_BIT];
        wtdi    = cmd_reg[jsc_pkg::CMD_WTDI_BIT];
        cap     = cmd_reg[jsc_pkg::CMD_CAPTURE_BIT];
        param   = {b, p0_reg};

        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        p0_next    = p0_reg;
        loop_next  = loop_reg;
        div5_next  = div5_reg;
        mode_next  = mode_reg;
        n          = 2'd0;
        set_div    = 1'b0;
        r0         = '0;
        r1         = '0;

        case (phase_reg)
            PH_LEN_LO:
            begin
                len_next = {8'd0, b};
                if (!bitmode)
                    phase_next = PH_LEN_HI;
                else if (tms)
                    phase_next = PH_TMS;
                else if (wtdi)
                    phase_next = PH_DATA;
                else
                begin
                    r0 = shift_word(jsc_pkg::ALL_ONES_BYTE, {1'b0, b[2:0]} + 4'd1,
                                    17'd1, jsc_pkg::HOLD_NONE, mode_reg, cap);
                    n          = 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            PH_LEN_HI:
            begin
                len_next = {b, len_reg[7:0]};
                if (tms)
                    phase_next = PH_TMS;
                else if (wtdi)
                    phase_next = PH_DATA;
                else
                begin
                    // read-only byte run: one request carries the whole length
                    r0 = shift_word(jsc_pkg::ALL_ONES_BYTE, 4'd8, 17'(len_next) + 17'd1,
                                    jsc_pkg::HOLD_NONE, mode_reg, cap);
                    n          = 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            PH_DATA:
            begin
                r0 = shift_word(b, bitmode ? ({1'b0, len_reg[2:0]} + 4'd1) : 4'd8,
                                17'd1, jsc_pkg::HOLD_NONE, mode_reg, cap);
                n = 2'd1;
                if (bitmode || (len_reg == 16'd0))
                    phase_next = PH_IDLE;
                len_next = len_reg - 16'd1;
            end
            PH_TMS:
            begin
                r0 = shift_word(b, {1'b0, len_reg[2:0]} + 4'd1, 17'd1,
                                b[7] ? jsc_pkg::HOLD_HIGH : jsc_pkg::HOLD_LOW, mode_reg, cap);
                n          = 2'd1;
                phase_next = PH_IDLE;
            end
            PH_PARAM0:
            begin
                p0_next = b;
                if (cmd_reg == jsc_pkg::OP_CLK_BYTES)
                begin
                    r0.kind        = jsc_pkg::KIND_CLOCK;
                    r0.clock_count = 20'(b) + 20'd1;
                    n              = 2'd1;
                    phase_next     = PH_IDLE;
                end
                else
                    phase_next = PH_PARAM1;
            end
            PH_PARAM1:
            begin
                if (cmd_reg == jsc_pkg::OP_SET_DIVISOR)
                    set_div = 1'b1;
                else if (cmd_reg == jsc_pkg::OP_CLK_BYTES8)
                begin
                    r0.kind        = jsc_pkg::KIND_CLOCK;
                    r0.clock_count = {17'(param) + 17'd1, 3'b000};
                    n              = 2'd1;
                end
                else if (cmd_reg == jsc_pkg::OP_SET_LOW)
                begin
                    r0.kind      = jsc_pkg::KIND_PINS;
                    r0.data_byte = {4'd0, p0_reg[3:0]};
                    r0.pin_dir   = b[3:0];
                    n            = 2'd1;
                end
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
                cmd_next   = b;
                if (b[jsc_pkg::CMD_SPECIAL_BIT])
                begin
                    case (b)
                        jsc_pkg::OP_SET_LOW, jsc_pkg::OP_SET_HIGH, jsc_pkg::OP_SET_DIVISOR,
                        jsc_pkg::OP_CLK_BYTES, jsc_pkg::OP_CLK_BYTES8:
                            phase_next = PH_PARAM0;
                        jsc_pkg::OP_READ_LOW:
                        begin
                            r0 = reply_word({4'd0, item.pin_levels});
                            n  = 2'd1;
                        end
                        jsc_pkg::OP_READ_HIGH:
                        begin
                            r0 = reply_word(jsc_pkg::ALL_ONES_BYTE);
                            n  = 2'd1;
                        end
                        jsc_pkg::OP_LOOP_ON:  loop_next = 1'b1;
                        jsc_pkg::OP_LOOP_OFF: loop_next = 1'b0;
                        jsc_pkg::OP_FLUSH:
                        begin
                            r0.kind = jsc_pkg::KIND_FLUSH;
                            n       = 2'd1;
                        end
                        jsc_pkg::OP_DIV5_OFF: div5_next = 1'b0;
                        jsc_pkg::OP_DIV5_ON:  div5_next = 1'b1;
                        jsc_pkg::OP_IGNORE_88, jsc_pkg::OP_IGNORE_89, jsc_pkg::OP_IGNORE_8C,
                        jsc_pkg::OP_IGNORE_8D, jsc_pkg::OP_IGNORE_96, jsc_pkg::OP_IGNORE_97:
                            ;
                        default:
                        begin
                            r0 = reply_word(jsc_pkg::BAD_CMD_BYTE);
                            r1 = reply_word(b);
                            n  = 2'd2;
                        end
                    endcase
                end
                else if (b[jsc_pkg::CMD_TMS_BIT])
                begin
                    // TMS shifts are LSB first only
                    if (b[jsc_pkg::CMD_LSB_BIT])
                    begin
                        mode_next  = b[jsc_pkg::CMD_EDGE_BIT] ? jsc_pkg::MODE_TMS_E0
                                                              : jsc_pkg::MODE_TMS_E1;
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        r0 = reply_word(jsc_pkg::BAD_CMD_BYTE);
                        r1 = reply_word(b);
                        n  = 2'd2;
                    end
                end
                else
                begin
                    case ({b[jsc_pkg::CMD_LSB_BIT], b[jsc_pkg::CMD_EDGE_BIT]})
                        2'b00:   mode_next = jsc_pkg::MODE_MSB_E1;
                        2'b01:   mode_next = jsc_pkg::MODE_MSB_E0;
                        2'b10:   mode_next = jsc_pkg::MODE_LSB_E1;
                        default: mode_next = jsc_pkg::MODE_LSB_E0;
                    endcase
                    phase_next = PH_LEN_LO;
                end
            end
        endcase

        r0.half_period_delay = delay_value;
        r0.loopback          = loop_next;
        r0.last              = (n == 2'd1);
        r1.half_period_delay = delay_value;
        r1.loopback          = loop_next;
        r1.last              = (n == 2'd2);

        emit.count  = n;
        emit.first  = r0;
        emit.second = r1;

        dreq.start   = fire && set_div;
        dreq.divider = param;
        dreq.div5    = div5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= 8'd0;
            len_reg   <= 16'd0;
            p0_reg    <= 8'd0;
            loop_reg  <= 1'b0;
            div5_reg  <= 1'b1;
            mode_reg  <= jsc_pkg::MODE_MSB_E1;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            p0_reg    <= p0_next;
            loop_reg  <= loop_next;
            div5_reg  <= div5_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

[rtl/jsc_out_fifo.sv]
`timescale 1ns / 1ps

module jsc_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jsc_pkg::emit_t      emit,
    output logic                valid,
    input  logic                ready,
    output jsc_pkg::out_word_t  data,
    output jsc_pkg::rq_status_t stat
);

    localparam int AW = jsc_pkg::RQ_AW;
    localparam int CW = jsc_pkg::RQ_CW;

    jsc_pkg::out_word_t     mem_reg [jsc_pkg::RQ_DEPTH];
    logic [AW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          push_n;
    logic                   pop;

    always_comb
    begin
        push_n      = push ? CW'(emit.count) : '0;
        pop         = valid && ready;
        wr_ptr_next = wr_ptr_reg + AW'(push_n);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + push_n - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (emit.count != 2'd0))
            mem_reg[wr_ptr_reg] <= emit.first;
        if (push && (emit.count == 2'd2))
            mem_reg[wr_ptr_reg + AW'(1)] <= emit.second;
    end

    assign valid      = (count_reg != '0);
    assign data       = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.free  = CW'(jsc_pkg::RQ_DEPTH) - count_reg;

endmodule

[rtl/jtag_shift_command_parser_top.sv]
`timescale 1ns / 1ps

// Command byte parser for a JTAG adapter front end.
//
// Host side (host_valid / host_ready / host_data): one command stream word
// per handshake, carrying the next byte and the sampled pin levels. Request
// side (req_valid / req_ready / req_data): shift, pin, clock, flush and reply
// words for the shift engine; req_data.last marks the final word caused by
// one host byte (an unknown opcode gives the two-word 0xFA + opcode reply).
//
// Timing: a host word accepted at the handshake lands in the input register,
// is parsed from there, and its request words pass through the request
// queue before the first is offered. Throughput: one host word per cycle
// while parsing is not held. After the set-divisor command the next byte
// waits while the delay unit's reciprocal multiply finds the new half-period.
//
// Stall: parsed words go into a four-entry request queue. Parsing holds when
// the queue lacks room for a byte's words, the input register then stays
// full and host_ready drops. host_ready never depends on req_ready directly.
//
// Reset: parser idle, queue empty, half-period delay 1, divide-by-five on,
// loopback off.
module jtag_shift_command_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               host_valid,
    output logic               host_ready,
    input  jsc_pkg::in_word_t  host_data,
    output logic               req_valid,
    input  logic               req_ready,
    output jsc_pkg::out_word_t req_data
);

    logic                in_vld_reg, in_vld_next;
    jsc_pkg::in_word_t   in_data_reg;
    logic                fire;
    logic                busy;
    logic [17:0]         delay_value;
    jsc_pkg::emit_t      emit;
    jsc_pkg::delay_req_t dreq;
    jsc_pkg::rq_status_t rq_stat;

    // Advance the parser only when the queue can take every word of this byte
    assign fire = in_vld_reg && !busy && (rq_stat.free >= jsc_pkg::RQ_CW'(emit.count));

    assign host_ready = !in_vld_reg || fire;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (host_valid && host_ready)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    // Hold the byte until the parser takes it
    always_ff @(posedge clk)
    begin
        if (host_valid && host_ready)
            in_data_reg <= host_data;
    end

    jsc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (in_data_reg),
        .delay_value (delay_value),
        .emit        (emit),
        .dreq        (dreq)
    );

    jsc_delay u_delay (
        .clk         (clk),
        .rst_n       (rst_n),
        .dreq        (dreq),
        .delay_value (delay_value),
        .busy        (busy)
    );

    jsc_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .emit  (emit),
        .valid (req_valid),
        .ready (req_ready),
        .data  (req_data),
        .stat  (rq_stat)
    );

    // The request queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rq_stat.count <= jsc_pkg::RQ_CW'(jsc_pkg::RQ_DEPTH))
        else $error("request queue over depth");

    // A divisor update blocks parsing for the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |=> !fire)
        else $error("parsed a byte while the delay was being updated");

    // A two-word reply marks only its second word as last
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (emit.count == 2'd2)) |-> (!emit.first.last && emit.second.last))
        else $error("wrong last flags on a word pair");

    // A word held in the input register while parsing is held stays pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !fire) |=> in_vld_reg && $stable(in_data_reg))
        else $error("input word lost while parsing was held");

endmodule

[tb/sv/jsc_request_checker.sv]
`timescale 1ns / 1ps

module jsc_request_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               host_valid,
    input  logic               host_ready,
    input  jsc_pkg::in_word_t  host_data,
    input  logic               req_valid,
    input  logic               req_ready,
    input  jsc_pkg::out_word_t req_data,
    output int                 mismatches,
    output int                 outstanding
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_TMS,
        PH_PARAM0,
        PH_PARAM1
    } parse_phase_t;

    parse_phase_t phase;
    logic [7:0]   cur_cmd;
    logic [15:0]  rem_len;
    logic [7:0]   param_lo;
    logic [17:0]  delay;
    logic         loop_on;
    logic         div5;
    logic [2:0]   mode;

    jsc_pkg::out_word_t staged [2];
    int                 n_staged;
    jsc_pkg::out_word_t expected_requests [$];
    jsc_pkg::out_word_t oldest;
    int                 tally = 0;

    function automatic logic [17:0] half_period(input logic [15:0] d, input logic fast);
        logic [31:0] q;
        if (fast)
        begin
            case (d)
                16'd0:   q = 32'd1;
                16'd1:   q = 32'd5;
                16'd2:   q = 32'd8;
                16'd3:   q = 32'd12;
                16'd4:   q = 32'd16;
                16'd5:   q = 32'd20;
                default: q = (32'd1000 * d + 32'd290) / 32'd258;
            endcase
        end
        else
        begin
            case (d)
                16'd0, 16'd1, 16'd2, 16'd3, 16'd4: q = 32'd1;
                16'd5:                             q = 32'd2;
                16'd6:                             q = 32'd3;
                16'd7, 16'd8:                      q = 32'd4;
                16'd9:                             q = 32'd5;
                16'd10:                            q = 32'd6;
                16'd11:                            q = 32'd7;
                16'd12, 16'd13, 16'd14:            q = 32'd8;
                16'd15:                            q = 32'd9;
                default:                           q = (32'd100 * d - 32'd255) / 32'd129;
            endcase
        end
        return q[17:0];
    endfunction

    function automatic jsc_pkg::out_word_t blank_word(input logic [2:0] kind);
        jsc_pkg::out_word_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic jsc_pkg::out_word_t shift_word(input logic [7:0] data,
                                                      input logic [3:0] bits,
                                                      input logic [16:0] rep,
                                                      input logic [1:0] hold);
        jsc_pkg::out_word_t r;
        r = blank_word(jsc_pkg::KIND_SHIFT);
        r.data_byte    = data;
        r.shift_mode   = mode;
        r.bit_count    = bits;
        r.repeat_count = rep;
        r.capture_tdo  = cur_cmd[jsc_pkg::CMD_CAPTURE_BIT];
        r.tdi_hold     = hold;
        return r;
    endfunction

    function automatic jsc_pkg::out_word_t clock_word(input logic [19:0] pulses);
        jsc_pkg::out_word_t r;
        r = blank_word(jsc_pkg::KIND_CLOCK);
        r.clock_count = pulses;
        return r;
    endfunction

    function automatic jsc_pkg::out_word_t reply_word(input logic [7:0] b);
        jsc_pkg::out_word_t r;
        r = blank_word(jsc_pkg::KIND_REPLY);
        r.data_byte = b;
        return r;
    endfunction

    task automatic stage(input jsc_pkg::out_word_t w);
        staged[n_staged] = w;
        n_staged++;
    endtask

    task automatic reject(input logic [7:0] op);
        stage(reply_word(jsc_pkg::BAD_CMD_BYTE));
        stage(reply_word(op));
    endtask

    // Decode the first byte of a command.
    task automatic start_command(input logic [7:0] b, input logic [3:0] pins);
        cur_cmd = b;
        if (b[jsc_pkg::CMD_SPECIAL_BIT])
        begin
            case (b)
                jsc_pkg::OP_SET_LOW, jsc_pkg::OP_SET_HIGH, jsc_pkg::OP_SET_DIVISOR,
                jsc_pkg::OP_CLK_BYTES, jsc_pkg::OP_CLK_BYTES8:
                    phase = PH_PARAM0;
                jsc_pkg::OP_READ_LOW:  stage(reply_word({4'h0, pins}));
                jsc_pkg::OP_READ_HIGH: stage(reply_word(jsc_pkg::ALL_ONES_BYTE));
                jsc_pkg::OP_LOOP_ON:   loop_on = 1'b1;
                jsc_pkg::OP_LOOP_OFF:  loop_on = 1'b0;
                jsc_pkg::OP_FLUSH:     stage(blank_word(jsc_pkg::KIND_FLUSH));
                jsc_pkg::OP_DIV5_OFF:  div5 = 1'b0;
                jsc_pkg::OP_DIV5_ON:   div5 = 1'b1;
                jsc_pkg::OP_IGNORE_88, jsc_pkg::OP_IGNORE_89, jsc_pkg::OP_IGNORE_8C,
                jsc_pkg::OP_IGNORE_8D, jsc_pkg::OP_IGNORE_96, jsc_pkg::OP_IGNORE_97: ;
                default:               reject(b);
            endcase
        end
        else if (b[jsc_pkg::CMD_TMS_BIT])
        begin
            // TMS shifts exist only in LSB-first form
            if (b[jsc_pkg::CMD_LSB_BIT])
            begin
                mode  = b[jsc_pkg::CMD_EDGE_BIT] ? jsc_pkg::MODE_TMS_E0 : jsc_pkg::MODE_TMS_E1;
                phase = PH_LEN_LO;
            end
            else
            begin
                reject(b);
            end
        end
        else
        begin
            case ({b[jsc_pkg::CMD_LSB_BIT], b[jsc_pkg::CMD_EDGE_BIT]})
                2'b00:   mode = jsc_pkg::MODE_MSB_E1;
                2'b01:   mode = jsc_pkg::MODE_MSB_E0;
                2'b10:   mode = jsc_pkg::MODE_LSB_E1;
                default: mode = jsc_pkg::MODE_LSB_E0;
            endcase
            phase = PH_LEN_LO;
        end
    endtask

    // Advance the parser by one host byte and queue the words it causes.
    task automatic parse_host_byte(input jsc_pkg::in_word_t w);
        logic [7:0]         b;
        logic               bitmode;
        logic               tms;
        logic               wtdi;
        logic [15:0]        pair;
        jsc_pkg::out_word_t r;
        b        = w.rx_byte;
        bitmode  = cur_cmd[jsc_pkg::CMD_BITMODE_BIT];
        tms      = cur_cmd[jsc_pkg::CMD_TMS_BIT];
        wtdi     = cur_cmd[jsc_pkg::CMD_WTDI_BIT];
        n_staged = 0;
        case (phase)
            PH_LEN_LO:
            begin
                rem_len = {8'h00, b};
                if (!bitmode)
                begin
                    phase = PH_LEN_HI;
                end
                else if (tms)
                begin
                    phase = PH_TMS;
                end
                else if (wtdi)
                begin
                    phase = PH_DATA;
                end
                else
                begin
                    stage(shift_word(jsc_pkg::ALL_ONES_BYTE, {1'b0, b[2:0]} + 4'd1, 17'd1,
                                     jsc_pkg::HOLD_NONE));
                    phase = PH_IDLE;
                end
            end
            PH_LEN_HI:
            begin
                rem_len = {b, rem_len[7:0]};
                if (tms)
                begin
                    phase = PH_TMS;
                end
                else if (wtdi)
                begin
                    phase = PH_DATA;
                end
                else
                begin
                    stage(shift_word(jsc_pkg::ALL_ONES_BYTE, 4'd8, {1'b0, rem_len} + 17'd1,
                                     jsc_pkg::HOLD_NONE));
                    phase = PH_IDLE;
                end
            end
            PH_DATA:
            begin
                stage(shift_word(b, bitmode ? {1'b0, rem_len[2:0]} + 4'd1 : 4'd8, 17'd1,
                                 jsc_pkg::HOLD_NONE));
                if (bitmode || rem_len == 16'd0)
                    phase = PH_IDLE;
                rem_len = rem_len - 16'd1;
            end
            PH_TMS:
            begin
                stage(shift_word(b, {1'b0, rem_len[2:0]} + 4'd1, 17'd1,
                                 b[7] ? jsc_pkg::HOLD_HIGH : jsc_pkg::HOLD_LOW));
                phase = PH_IDLE;
            end
            PH_PARAM0:
            begin
                param_lo = b;
                if (cur_cmd == jsc_pkg::OP_CLK_BYTES)
                begin
                    stage(clock_word({12'd0, b} + 20'd1));
                    phase = PH_IDLE;
                end
                else
                begin
                    phase = PH_PARAM1;
                end
            end
            PH_PARAM1:
            begin
                pair = {b, param_lo};
                if (cur_cmd == jsc_pkg::OP_SET_DIVISOR)
                begin
                    delay = half_period(pair, div5);
                end
                else if (cur_cmd == jsc_pkg::OP_CLK_BYTES8)
                begin
                    stage(clock_word(({4'd0, pair} + 20'd1) << 3));
                end
                else if (cur_cmd == jsc_pkg::OP_SET_LOW)
                begin
                    r = blank_word(jsc_pkg::KIND_PINS);
                    r.data_byte = {4'h0, param_lo[3:0]};
                    r.pin_dir   = b[3:0];
                    stage(r);
                end
                phase = PH_IDLE;
            end
            default:
            begin
                phase = PH_IDLE;
                start_command(b, w.pin_levels);
            end
        endcase
        for (int i = 0; i < n_staged; i++)
        begin
            r = staged[i];
            r.half_period_delay = delay;
            r.loopback          = loop_on;
            r.last              = (i == n_staged - 1);
            expected_requests.push_back(r);
        end
    endtask

    function automatic int field_diff(input string name, input logic [19:0] want,
                                      input logic [19:0] got);
        if (want !== got)
        begin
            $display("%0t: request field %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic compare_request(input jsc_pkg::out_word_t want,
                                   input jsc_pkg::out_word_t got);
        int bad;
        bad = field_diff("kind", 20'(want.kind), 20'(got.kind))
            + field_diff("data_byte", 20'(want.data_byte), 20'(got.data_byte))
            + field_diff("pin_dir", 20'(want.pin_dir), 20'(got.pin_dir))
            + field_diff("shift_mode", 20'(want.shift_mode), 20'(got.shift_mode))
            + field_diff("bit_count", 20'(want.bit_count), 20'(got.bit_count))
            + field_diff("repeat_count", 20'(want.repeat_count), 20'(got.repeat_count))
            + field_diff("capture_tdo", 20'(want.capture_tdo), 20'(got.capture_tdo))
            + field_diff("tdi_hold", 20'(want.tdi_hold), 20'(got.tdi_hold))
            + field_diff("clock_count", want.clock_count, got.clock_count)
            + field_diff("half_period_delay", 20'(want.half_period_delay),
                         20'(got.half_period_delay))
            + field_diff("loopback", 20'(want.loopback), 20'(got.loopback))
            + field_diff("last", 20'(want.last), 20'(got.last));
        if (bad != 0)
            tally++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase    = PH_IDLE;
            cur_cmd  = 8'h00;
            rem_len  = 16'h0000;
            param_lo = 8'h00;
            delay    = 18'd1;
            loop_on  = 1'b0;
            div5     = 1'b1;
            mode     = jsc_pkg::MODE_MSB_E1;
            expected_requests.delete();
            outstanding <= 0;
            mismatches  <= tally;
        end
        else
        begin
            if (host_valid && host_ready)
                parse_host_byte(host_data);
            if (req_valid && req_ready)
            begin
                if (expected_requests.size() == 0)
                begin
                    $display("%0t: request word expected none, got %0h", $time, req_data);
                    tally++;
                end
                else
                begin
                    oldest = expected_requests.pop_front();
                    compare_request(oldest, req_data);
                end
            end
            outstanding <= expected_requests.size();
            mismatches  <= tally;
        end
    end

endmodule

[tb/sv/tb_jtag_shift_command_parser_top.sv]
`timescale 1ns / 1ps

module tb_jtag_shift_command_parser_top;

    // Random host bytes after the directed part, and the tail without idling.
    localparam int RANDOM_BYTES = 700;
    localparam int CALM_TAIL    = 100;
    // Quiet cycles (no word moves on either channel) before giving up.
    localparam int QUIET_LIMIT  = 1000;
    // Cycles to hold after the last expected word, to catch stray words.
    localparam int SETTLE_CYCLES = 20;

    // A high opcode that decodes to nothing and must draw the error pair.
    localparam logic [7:0] UNKNOWN_OP = 8'h90;

    logic               clk;
    logic               rst_n;
    logic               host_valid;
    logic               host_ready;
    jsc_pkg::in_word_t  host_data;
    logic               req_valid;
    logic               req_ready = 1'b0;
    jsc_pkg::out_word_t req_data;

    int        mismatches;
    int        outstanding;

    int        bytes_sent;
    logic      calm;
    int        send_odds;
    int        stall_odds = 0;
    int        stall_left = 0;
    int        stall_epoch = 0;
    int        quiet_cycles;

    jtag_shift_command_parser_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .host_valid (host_valid),
        .host_ready (host_ready),
        .host_data  (host_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data)
    );

    jsc_request_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .host_valid  (host_valid),
        .host_ready  (host_ready),
        .host_data   (host_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Request side: drop ready in random bursts. Re-pick the burst rate each time
    // stall_epoch wraps to zero, so that long stretches with no stall show up too.
    always @(posedge clk)
    begin
        if (stall_epoch == 0)
        begin
            case ($urandom_range(0, 2))
                0:       stall_odds = 0;
                1:       stall_odds = 3;
                default: stall_odds = 12;
            endcase
        end
        stall_epoch = (stall_epoch + 1) % 64;
        if (stall_left > 0)
        begin
            req_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            req_ready <= 1'b1;
            if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                stall_left = $urandom_range(1, 16);
        end
    end

    // Watchdog: count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (host_valid && host_ready) || (req_valid && req_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] shift_op(input logic tms, input logic capture,
                                            input logic wtdi, input logic lsb,
                                            input logic bitmode, input logic neg_edge);
        logic [7:0] op;
        op = 8'h00;
        op[jsc_pkg::CMD_TMS_BIT]     = tms;
        op[jsc_pkg::CMD_CAPTURE_BIT] = capture;
        op[jsc_pkg::CMD_WTDI_BIT]    = wtdi;
        op[jsc_pkg::CMD_LSB_BIT]     = lsb;
        op[jsc_pkg::CMD_BITMODE_BIT] = bitmode;
        op[jsc_pkg::CMD_EDGE_BIT]    = neg_edge;
        return op;
    endfunction

    // Offer one host word and hold it until accepted. Leave valid high on
    // return: the next call either replaces the payload in the same step or
    // drops valid for a gap.
    task automatic send_byte(input logic [7:0] b);
        jsc_pkg::in_word_t w;
        int                gap;
        w.rx_byte    = b;
        w.pin_levels = 4'($urandom_range(0, 15));
        if (!calm && send_odds != 0 && $urandom_range(1, send_odds) == 1)
        begin
            gap = $urandom_range(1, 16);
            host_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        host_valid <= 1'b1;
        host_data  <= w;
        @(posedge clk);
        while (!host_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_pair(input logic [7:0] op, input logic [15:0] value);
        send_byte(op);
        send_byte(value[7:0]);
        send_byte(value[15:8]);
    endtask

    // Set the divider, then flush so a result carries the new delay.
    task automatic send_divisor(input logic [15:0] divider);
        send_pair(jsc_pkg::OP_SET_DIVISOR, divider);
        send_byte(jsc_pkg::OP_FLUSH);
    endtask

    // Drop valid and hold the sender until every expected word has come out.
    // The extra edge lets the checker count the word just accepted.
    task automatic drain_requests();
        host_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_byte(jsc_pkg::OP_READ_LOW);
        send_byte(jsc_pkg::OP_READ_HIGH);
        send_byte(jsc_pkg::OP_LOOP_ON);
        send_byte(jsc_pkg::OP_FLUSH);
        send_byte(jsc_pkg::OP_LOOP_OFF);
        send_byte(UNKNOWN_OP);
        send_byte(jsc_pkg::ALL_ONES_BYTE);
        // TMS shift in MSB-first form is rejected like an unknown opcode
        send_byte(shift_op(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_byte(jsc_pkg::OP_IGNORE_88);
        send_byte(jsc_pkg::OP_IGNORE_89);
        send_byte(jsc_pkg::OP_IGNORE_8C);
        send_byte(jsc_pkg::OP_IGNORE_8D);
        send_byte(jsc_pkg::OP_IGNORE_96);
        send_byte(jsc_pkg::OP_IGNORE_97);
        send_pair(jsc_pkg::OP_SET_HIGH, 16'h3412);
        send_pair(jsc_pkg::OP_SET_LOW, 16'hFFFF);
        // read-only byte shift at full length: repeat count one past 16 bits
        send_pair(shift_op(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 16'hFFFF);
        // read-only bit shift: only the low three length bits count
        send_byte(shift_op(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        send_byte(jsc_pkg::ALL_ONES_BYTE);
        send_pair(shift_op(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1), 16'h0001);
        send_byte(8'h00);
        send_byte(jsc_pkg::ALL_ONES_BYTE);
        send_byte(shift_op(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_byte(8'h00);
        send_byte(8'hA5);
        // TMS shifts: data bit 7 picks the TDI level
        send_byte(shift_op(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        send_byte(8'h06);
        send_byte(8'h80);
        send_byte(shift_op(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
        send_byte(8'h07);
        send_byte(8'h7F);
        // TMS shift with a two-byte length still uses the three-bit rule
        send_pair(shift_op(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1), 16'hFF0F);
        send_byte(8'h3C);
        send_byte(jsc_pkg::OP_CLK_BYTES);
        send_byte(8'h00);
        send_byte(jsc_pkg::OP_CLK_BYTES);
        send_byte(jsc_pkg::ALL_ONES_BYTE);
        send_pair(jsc_pkg::OP_CLK_BYTES8, 16'hFFFF);
        send_pair(jsc_pkg::OP_CLK_BYTES8, 16'h0000);
        send_divisor(16'd5);
        send_divisor(16'd6);
        send_divisor(16'hFFFF);
        send_byte(jsc_pkg::OP_DIV5_OFF);
        send_divisor(16'd0);
        send_divisor(16'd15);
        send_divisor(16'd16);
        send_divisor(16'hFFFF);
        send_byte(jsc_pkg::OP_DIV5_ON);
        send_divisor(16'd0);
    endtask

    task automatic send_shift_command();
        logic [7:0]  op;
        logic [15:0] len;
        logic        tms;
        logic        wtdi;
        logic        bitmode;
        int          n_data;
        op = 8'($urandom_range(0, 127));
        // keep most TMS opcodes well-formed so they reach the data byte
        if (op[jsc_pkg::CMD_TMS_BIT] && $urandom_range(0, 9) != 0)
            op[jsc_pkg::CMD_LSB_BIT] = 1'b1;
        tms     = op[jsc_pkg::CMD_TMS_BIT];
        wtdi    = op[jsc_pkg::CMD_WTDI_BIT];
        bitmode = op[jsc_pkg::CMD_BITMODE_BIT];
        send_byte(op);
        if (bitmode)
        begin
            len = 16'($urandom_range(0, 255));
            send_byte(len[7:0]);
        end
        else
        begin
            if (wtdi && !tms)
                len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(8, 40))
                                                  : 16'($urandom_range(0, 7));
            else
                len = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
            send_byte(len[7:0]);
            send_byte(len[15:8]);
        end
        if (tms)
            n_data = 1;
        else if (wtdi)
            n_data = bitmode ? 1 : int'(len) + 1;
        else
            n_data = 0;
        // now and then cut the payload short so the next opcode lands as data
        if (n_data > 0 && $urandom_range(0, 19) == 0)
            n_data = $urandom_range(0, n_data - 1);
        repeat (n_data)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_command();
        int          pick;
        logic [15:0] value;
        // re-pick the sender's gap rate now and then
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       send_odds = 0;
                1:       send_odds = 3;
                default: send_odds = 10;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            send_shift_command();
        end
        else if (pick < 52)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_byte(jsc_pkg::OP_CLK_BYTES);
                send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                value = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
                send_pair(jsc_pkg::OP_CLK_BYTES8, value);
            end
        end
        else if (pick < 62)
        begin
            if ($urandom_range(0, 2) == 0)
                send_byte($urandom_range(0, 1) ? jsc_pkg::OP_DIV5_ON : jsc_pkg::OP_DIV5_OFF);
            case ($urandom_range(0, 3))
                0:       value = 16'($urandom_range(0, 16));
                1:       value = 16'hFFFF;
                default: value = 16'($urandom);
            endcase
            send_pair(jsc_pkg::OP_SET_DIVISOR, value);
        end
        else if (pick < 72)
        begin
            send_pair($urandom_range(0, 1) ? jsc_pkg::OP_SET_LOW : jsc_pkg::OP_SET_HIGH,
                      16'($urandom));
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 12))
                0:       send_byte(jsc_pkg::OP_READ_LOW);
                1:       send_byte(jsc_pkg::OP_READ_HIGH);
                2:       send_byte(jsc_pkg::OP_LOOP_ON);
                3:       send_byte(jsc_pkg::OP_LOOP_OFF);
                4:       send_byte(jsc_pkg::OP_FLUSH);
                5:       send_byte(jsc_pkg::OP_DIV5_OFF);
                6:       send_byte(jsc_pkg::OP_DIV5_ON);
                7:       send_byte(jsc_pkg::OP_IGNORE_88);
                8:       send_byte(jsc_pkg::OP_IGNORE_89);
                9:       send_byte(jsc_pkg::OP_IGNORE_8C);
                10:      send_byte(jsc_pkg::OP_IGNORE_8D);
                11:      send_byte(jsc_pkg::OP_IGNORE_96);
                default: send_byte(jsc_pkg::OP_IGNORE_97);
            endcase
        end
        else
        begin
            // noise: any byte at all, often an unknown opcode
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        host_valid  = 1'b0;
        host_data   = '0;
        bytes_sent  = 0;
        calm        = 1'b0;
        send_odds   = 4;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        // hold the sender until the request side has caught up
        drain_requests();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            calm = (bytes_sent >= RANDOM_BYTES - CALM_TAIL);
            send_random_command();
        end

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            if (outstanding != 0)
                $display("%0t: %0d request words never came", $time, outstanding);
            $display("status: fail");
        end
        $finish;
    end

endmodule
